// ----- rtl/adct_pkg.sv -----
// Shared types and constants for the address dedupe cooldown table.
// No dependencies; every other file in rtl/ imports this package.
package adct_pkg;

  localparam int ADDR_W         = 48;
  localparam int TIME_W         = 32;
  localparam int SLOT_FIELD_W   = 5;
  localparam int SLOTS_DEFAULT  = 32;
  localparam logic [TIME_W-1:0] COOLDOWN_RESET = 32'd10000;

  typedef struct packed {
    logic [ADDR_W-1:0] device_address;
    logic [TIME_W-1:0] now_ms;
  } item_t;

  typedef struct packed {
    logic                    suppress;
    logic                    newly_stored;
    logic [SLOT_FIELD_W-1:0] slot_used;
  } result_t;

  // one table entry
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [TIME_W-1:0] seen_ms;
  } entry_t;

  // search token flags handed from cell to cell
  typedef struct packed {
    logic active;
    logic hit;
    logic suppress;
  } tok_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

endpackage

// ----- rtl/adct_cell.sv -----
// One table slot: holds an address and its last-accepted time, checks the
// passing search token against it and forwards the token to the next slot.
// Depends on adct_pkg.
module adct_cell #(
  parameter int SLOTS  = adct_pkg::SLOTS_DEFAULT,
  parameter int INDEX  = 0,
  parameter int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  adct_pkg::item_t            query,
  input  logic [adct_pkg::TIME_W-1:0] cooldown,
  input  adct_pkg::tok_t             tok_in,
  input  logic [SLOT_W-1:0]          idx_in,
  output adct_pkg::tok_t             tok_out,
  output logic [SLOT_W-1:0]          idx_out,
  input  logic                       wr_en,
  input  logic [SLOT_W-1:0]          wr_slot,
  input  adct_pkg::entry_t           wr_entry
);
  import adct_pkg::*;

  localparam logic [SLOT_W-1:0] MY_IDX = SLOT_W'(INDEX);

  entry_t            entry;
  logic              match;
  logic [TIME_W-1:0] elapsed;

  assign match   = (entry.addr == query.device_address);
  assign elapsed = query.now_ms - entry.seen_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else if (wr_en && (wr_slot == MY_IDX)) begin
      entry <= wr_entry;
    end
  end

  // first match along the chain wins; later cells pass it through
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out.active <= tok_in.active;
      if (tok_in.active && !tok_in.hit && match) begin
        tok_out.hit      <= 1'b1;
        tok_out.suppress <= (elapsed < cooldown);
      end else begin
        tok_out.hit      <= tok_in.hit;
        tok_out.suppress <= tok_in.suppress;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in.active && !tok_in.hit && match) begin
      idx_out <= MY_IDX;
    end else begin
      idx_out <= idx_in;
    end
  end

endmodule

// ----- rtl/adct_ctrl.sv -----
// Sequencer: takes items and config writes, launches the search token into
// the cell chain, applies the table update and holds the result.
// Depends on adct_pkg.
module adct_ctrl #(
  parameter int SLOTS  = adct_pkg::SLOTS_DEFAULT,
  parameter int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  adct_pkg::item_t             item,
  output logic                        result_valid,
  input  logic                        result_stall,
  output adct_pkg::result_t           result,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [adct_pkg::TIME_W-1:0] cfg_data,
  output adct_pkg::item_t             query,
  output logic [adct_pkg::TIME_W-1:0] cooldown,
  output adct_pkg::tok_t              launch_tok,
  input  adct_pkg::tok_t              last_tok,
  input  logic [SLOT_W-1:0]           last_idx,
  output logic                        wr_en,
  output logic [SLOT_W-1:0]           wr_slot,
  output adct_pkg::entry_t            wr_entry
);
  import adct_pkg::*;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  state_t            state;
  state_t            state_next;
  logic              launch;
  logic [SLOT_W-1:0] pointer;
  logic              res_hit;
  logic              res_suppress;
  logic [SLOT_W-1:0] res_idx;
  logic              accept;
  logic              out_free;
  logic              finish;

  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign cfg_ready  = 1'b1;
  assign out_free   = !result_valid || !result_stall;
  assign finish     = (state == ST_FINISH) && out_free;

  assign launch_tok.active   = launch;
  assign launch_tok.hit      = 1'b0;
  assign launch_tok.suppress = 1'b0;

  // suppressed sightings leave the table untouched
  assign wr_en          = finish && !res_suppress;
  assign wr_slot        = res_hit ? res_idx : pointer;
  assign wr_entry.addr    = query.device_address;
  assign wr_entry.seen_ms = query.now_ms;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (accept) state_next = ST_SCAN;
      ST_SCAN:   if (last_tok.active) state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      launch   <= 1'b0;
      pointer  <= '0;
      cooldown <= COOLDOWN_RESET;
    end else begin
      state  <= state_next;
      launch <= accept;
      if (cfg_valid && cfg_ready) begin
        cooldown <= cfg_data;
      end
      if (finish && !res_hit) begin
        pointer <= (pointer == LAST_SLOT) ? '0 : pointer + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      query <= item;
    end
    if ((state == ST_SCAN) && last_tok.active) begin
      res_hit      <= last_tok.hit;
      res_suppress <= last_tok.hit && last_tok.suppress;
      res_idx      <= last_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (finish) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      result.suppress     <= res_suppress;
      result.newly_stored <= !res_hit;
      result.slot_used    <= SLOT_FIELD_W'(res_hit ? res_idx : pointer);
    end
  end

endmodule

// ----- rtl/address_dedupe_cooldown_table_unit.sv -----
// Address dedupe table with cooldown. Each transfer on the item channel
// brings a 48-bit address and a millisecond time and yields one result:
// suppressed if the address was accepted less than cooldown_ms ago, newly
// stored if it was absent (written at a round-robin slot), else passed with
// its time refreshed. The table is a chain of SLOTS cells; a search token
// walks one cell per cycle, the controller captures the last cell's token
// and then moves the result into the output register. The next item is
// accepted only after that move, so one item is in flight at a time. A
// result still held by result_stall delays that move. Table contents
// clear at reset. The user must write cooldown_ms through the cfg
// channel only while no item is in flight; the block itself does not
// enforce this.
// Depends on adct_pkg, adct_cell and adct_ctrl.
module address_dedupe_cooldown_table_unit #(
  parameter int SLOTS = adct_pkg::SLOTS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  adct_pkg::item_t             item,
  output logic                        result_valid,
  input  logic                        result_stall,
  output adct_pkg::result_t           result,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [adct_pkg::TIME_W-1:0] cfg_data
);
  import adct_pkg::*;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  item_t             query;
  logic [TIME_W-1:0] cooldown;
  tok_t              tok [SLOTS+1];
  logic [SLOT_W-1:0] idx [SLOTS+1];
  logic              wr_en;
  logic [SLOT_W-1:0] wr_slot;
  entry_t            wr_entry;

  assign idx[0] = '0;

  adct_ctrl #(
    .SLOTS  (SLOTS),
    .SLOT_W (SLOT_W)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .query        (query),
    .cooldown     (cooldown),
    .launch_tok   (tok[0]),
    .last_tok     (tok[SLOTS]),
    .last_idx     (idx[SLOTS]),
    .wr_en        (wr_en),
    .wr_slot      (wr_slot),
    .wr_entry     (wr_entry)
  );

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    adct_cell #(
      .SLOTS  (SLOTS),
      .INDEX  (i),
      .SLOT_W (SLOT_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .query    (query),
      .cooldown (cooldown),
      .tok_in   (tok[i]),
      .idx_in   (idx[i]),
      .tok_out  (tok[i+1]),
      .idx_out  (idx[i+1]),
      .wr_en    (wr_en),
      .wr_slot  (wr_slot),
      .wr_entry (wr_entry)
    );
  end

endmodule
